// ----- hdl/mrb_pkg.sv -----
// Shared types and constants of the message ring buffer.
package mrb_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MSG_LEN_W = 5;

  localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] WPOS_MAX = 8'hFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic [BYTE_W-1:0] max_len;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    out_byte;
    status_e              status;
    logic [MSG_LEN_W-1:0] msg_length;
    logic                 last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_LEN,
    S_LOAD,
    S_STAT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept_wr;
    logic wr_finish;
    logic rd_start;
    logic emit_empty;
    logic copy_step;
    logic emit_invalid;
    logic stream_start;
    logic load_byte;
    logic emit_ok;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic ring_empty;
    logic commit_copy;
    logic len_too_big;
    logic len_zero;
    logic stream_last;
    logic copy_done;
  } sts_t;

endpackage

// ----- hdl/message_ring_buffer.sv -----
// Write: one byte per cycle while in_ready is high; the status of the last byte appears
// the next cycle. A committed message is copied from staging into its slot, input held
// off meanwhile. Read: empty status the next cycle; else a slot length lookup, then an
// invalid status if the length reaches the limit, or one text byte per cycle from the slot
// memory read port while the output is free and the final status. Reset (async, active
// low) clears pointers, fill level, write run and out_valid; slots unset until written.
module message_ring_buffer #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned SLOT_BYTES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mrb_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrb_pkg::out_item_t out_data_o
);
  import mrb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_data_i.opcode),
    .last_byte_i (in_data_i.last_byte),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  mrb_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .sts_o       (sts)
  );

  // The last byte of a write run is followed by its status on the output
  a_wr_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.opcode == OP_WRITE) && in_data_i.last_byte)
    |=> (out_valid_o && out_data_o.last_result && (out_data_o.out_byte == NUL_BYTE)))
    else $error("write run ended without a status transfer");

  // Stream bytes carry status ok and no length
  a_stream_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last_result)
    |-> ((out_data_o.status == ST_OK) && (out_data_o.msg_length == '0)))
    else $error("stream byte with status or length set");

  // Closing a read run presents the final ok status
  a_read_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_ok |=> (out_valid_o && out_data_o.last_result && (out_data_o.status == ST_OK)))
    else $error("read run closed without final status");

  // No result is loaded while the output register is still held
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_byte || cmd.emit_ok || cmd.emit_invalid || cmd.emit_empty || cmd.wr_finish)
    |-> sts.out_free)
    else $error("output register overwritten");

endmodule

// ----- hdl/mrb_ctrl.sv -----
// Controller state machine of the message ring buffer.
module mrb_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         opcode_i,
  input  logic         last_byte_i,
  input  mrb_pkg::sts_t sts_i,
  output logic         in_ready_o,
  output mrb_pkg::cmd_t cmd_o
);
  import mrb_pkg::*;

  state_e state_q, state_d;
  logic   in_ready;
  logic   accept;

  assign in_ready   = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready;
  assign in_ready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_WRITE) begin
            if (last_byte_i && sts_i.commit_copy) state_d = S_COPY;
          end else if (!sts_i.ring_empty) begin
            state_d = S_LEN;
          end
        end
      end
      S_COPY: begin
        if (sts_i.copy_done) state_d = S_IDLE;
      end
      S_LEN: begin
        if (sts_i.out_free) begin
          if (sts_i.len_too_big) state_d = S_IDLE;
          else if (sts_i.len_zero) state_d = S_STAT;
          else state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.out_free && sts_i.stream_last) state_d = S_STAT;
      end
      S_STAT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_WRITE) begin
            cmd_o.accept_wr = 1'b1;
            cmd_o.wr_finish = last_byte_i;
          end else if (sts_i.ring_empty) begin
            cmd_o.emit_empty = 1'b1;
          end else begin
            cmd_o.rd_start = 1'b1;
          end
        end
      end
      S_COPY: cmd_o.copy_step = 1'b1;
      S_LEN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_invalid = sts_i.len_too_big;
          cmd_o.stream_start = !sts_i.len_too_big;
        end
      end
      S_LOAD: cmd_o.load_byte = sts_i.out_free;
      S_STAT: cmd_o.emit_ok = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/mrb_datapath.sv -----
// Datapath of the message ring buffer: run state, staging and slot memories, output register.
module mrb_datapath #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned SLOT_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrb_pkg::cmd_t     cmd_i,
  input  mrb_pkg::in_item_t in_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output mrb_pkg::out_item_t out_data_o,
  output mrb_pkg::sts_t     sts_o
);
  import mrb_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned FW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned LW = $clog2(SLOT_BYTES);
  localparam int unsigned MEM_DEPTH = SLOT_COUNT * (2 ** LW);

  // Ring pointers and fill level
  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic [FW-1:0] fill_q, fill_d;

  // Write run state
  logic [BYTE_W-1:0] wpos_q, wpos_d;
  logic              zseen_q, zseen_d;
  logic [LW-1:0]     tlen_q, tlen_d;

  // Copy from staging into the head slot
  logic [IW-1:0] cp_slot_q, cp_slot_d;
  logic [LW-1:0] cp_len_q, cp_len_d;
  logic [LW-1:0] cp_rd_q, cp_rd_d;
  logic [LW-1:0] cp_wr_q, cp_wr_d;
  logic          cp_pend_q, cp_pend_d;
  logic          cp_issue;

  // Read run
  logic [BYTE_W-1:0] maxlen_q;
  logic [LW-1:0]     len_q;
  logic [LW-1:0]     rd_idx_q, rd_idx_d;
  logic [LW-1:0]     rd_next;

  // Memories and their registered read data
  logic [BYTE_W-1:0] stage_mem [SLOT_BYTES];
  logic [BYTE_W-1:0] slot_mem  [MEM_DEPTH];
  logic [LW-1:0]     len_mem   [SLOT_COUNT];
  logic [BYTE_W-1:0] stage_rd_q;
  logic [BYTE_W-1:0] slot_rd_q;
  logic [LW-1:0]     len_rd_q;

  logic              slot_rd_en;
  logic [LW-1:0]     slot_rd_off;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      out_load;
  logic      out_free;

  // Write classification for the item at the input
  logic              is_nul;
  logic              stage_ok;
  logic              zs_new;
  logic [LW-1:0]     tl_new;
  logic [BYTE_W-1:0] wp_new;
  logic              wr_bad;
  logic              ring_full;
  logic              commit;
  status_e           wr_status;

  logic [IW-1:0] head_inc, tail_inc;

  assign out_free = !out_valid_q || out_ready_i;

  assign is_nul    = (in_data_i.data_byte == NUL_BYTE);
  assign stage_ok  = !zseen_q && !is_nul && (tlen_q < LW'(SLOT_BYTES - 1));
  assign zs_new    = zseen_q || is_nul;
  assign tl_new    = stage_ok ? tlen_q + 1'b1 : tlen_q;
  assign wp_new    = (wpos_q == WPOS_MAX) ? WPOS_MAX : wpos_q + 1'b1;
  assign wr_bad    = (wp_new >= BYTE_W'(SLOT_BYTES)) || !zs_new;
  assign ring_full = (fill_q >= FW'(SLOT_COUNT));
  assign commit    = !wr_bad && !ring_full;

  always_comb begin
    if (wr_bad) wr_status = ST_INVALID;
    else if (ring_full) wr_status = ST_FULL;
    else wr_status = ST_OK;
  end

  assign head_inc = (head_q == IW'(SLOT_COUNT - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == IW'(SLOT_COUNT - 1)) ? '0 : tail_q + 1'b1;

  assign cp_issue = cmd_i.copy_step && (cp_rd_q != cp_len_q);
  assign rd_next  = rd_idx_q + 1'b1;

  assign sts_o.out_free    = out_free;
  assign sts_o.ring_empty  = (fill_q == '0);
  assign sts_o.commit_copy = commit && (tl_new != '0);
  assign sts_o.len_too_big = (BYTE_W'(len_rd_q) >= maxlen_q);
  assign sts_o.len_zero    = (len_rd_q == '0);
  assign sts_o.stream_last = (rd_next == len_q);
  assign sts_o.copy_done   = cp_pend_q && ((cp_wr_q + 1'b1) == cp_len_q);

  // Control registers
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    wpos_d    = wpos_q;
    zseen_d   = zseen_q;
    tlen_d    = tlen_q;
    cp_slot_d = cp_slot_q;
    cp_len_d  = cp_len_q;
    cp_rd_d   = cp_rd_q;
    cp_wr_d   = cp_wr_q;
    cp_pend_d = cp_pend_q;
    rd_idx_d  = rd_idx_q;

    if (cmd_i.accept_wr) begin
      wpos_d  = wp_new;
      zseen_d = zs_new;
      tlen_d  = tl_new;
    end
    if (cmd_i.wr_finish) begin
      // Clear the run whatever the outcome
      wpos_d  = '0;
      zseen_d = 1'b0;
      tlen_d  = '0;
      if (commit) begin
        cp_slot_d = head_q;
        cp_len_d  = tl_new;
        cp_rd_d   = '0;
        cp_wr_d   = '0;
        cp_pend_d = 1'b0;
        head_d    = head_inc;
        fill_d    = fill_q + 1'b1;
      end
    end
    if (cmd_i.copy_step) begin
      cp_pend_d = cp_issue;
      if (cp_issue) cp_rd_d = cp_rd_q + 1'b1;
      if (cp_pend_q) cp_wr_d = cp_wr_q + 1'b1;
    end
    if (cmd_i.stream_start) rd_idx_d = '0;
    if (cmd_i.load_byte && !sts_o.stream_last) rd_idx_d = rd_next;
    if (cmd_i.emit_ok) begin
      tail_d = tail_inc;
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      wpos_q    <= '0;
      zseen_q   <= 1'b0;
      tlen_q    <= '0;
      cp_slot_q <= '0;
      cp_len_q  <= '0;
      cp_rd_q   <= '0;
      cp_wr_q   <= '0;
      cp_pend_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
      wpos_q    <= wpos_d;
      zseen_q   <= zseen_d;
      tlen_q    <= tlen_d;
      cp_slot_q <= cp_slot_d;
      cp_len_q  <= cp_len_d;
      cp_rd_q   <= cp_rd_d;
      cp_wr_q   <= cp_wr_d;
      cp_pend_q <= cp_pend_d;
      rd_idx_q  <= rd_idx_d;
    end
  end

  // Read run registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_start) maxlen_q <= in_data_i.max_len;
    if (cmd_i.stream_start) len_q <= len_rd_q;
  end

  // Staging memory: written per text byte, read during the copy
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_wr && stage_ok) stage_mem[tlen_q] <= in_data_i.data_byte;
    if (cp_issue) stage_rd_q <= stage_mem[cp_rd_q];
  end

  // Slot length memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_finish && commit) len_mem[head_q] <= tl_new;
    if (cmd_i.rd_start) len_rd_q <= len_mem[tail_q];
  end

  // Slot byte memory: copy writes, stream reads one ahead of the output
  assign slot_rd_en  = (cmd_i.stream_start && !sts_o.len_zero) ||
                       (cmd_i.load_byte && !sts_o.stream_last);
  assign slot_rd_off = cmd_i.stream_start ? '0 : rd_next;

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_step && cp_pend_q) slot_mem[{cp_slot_q, cp_wr_q}] <= stage_rd_q;
    if (slot_rd_en) slot_rd_q <= slot_mem[{tail_q, slot_rd_off}];
  end

  // Output register
  assign out_load = cmd_i.emit_empty || cmd_i.wr_finish || cmd_i.emit_invalid ||
                    cmd_i.load_byte || cmd_i.emit_ok;

  always_comb begin
    out_d             = out_q;
    out_valid_d       = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = NUL_BYTE;
      out_d.status      = ST_OK;
      out_d.msg_length  = '0;
      out_d.last_result = 1'b1;
      if (cmd_i.emit_empty) begin
        out_d.status = ST_EMPTY;
      end else if (cmd_i.wr_finish) begin
        out_d.status = wr_status;
      end else if (cmd_i.emit_invalid) begin
        out_d.status     = ST_INVALID;
        out_d.msg_length = MSG_LEN_W'(len_rd_q);
      end else if (cmd_i.load_byte) begin
        out_d.out_byte    = slot_rd_q;
        out_d.last_result = 1'b0;
      end else begin
        out_d.msg_length = MSG_LEN_W'(len_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- dv/message_ring_buffer_tb.sv -----
// Self-checking testbench for the message ring buffer: random and directed message traffic.
`timescale 1ns / 1ps

module message_ring_buffer_tb;
  import mrb_pkg::*;

  localparam int unsigned SLOT_COUNT  = 8;
  localparam int unsigned SLOT_BYTES  = 32;
  localparam int unsigned IDX_W       = $clog2(SLOT_COUNT);
  localparam int          HALF_PERIOD = 10;
  localparam int          RESET_CYCLES = 10;
  localparam int          IDLE_PCT    = 26;
  localparam int          HOLD_CYCLES = 300;
  localparam int          HOLD_AFTER  = 40;
  localparam int          STALL_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 60;
  localparam int          FEED_ITEMS  = 140;
  localparam int          DRV_CALM_LO = 30;
  localparam int          DRV_CALM_HI = 80;
  localparam int          RCV_CALM_LO = 50;
  localparam int          RCV_CALM_HI = 90;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  op_feed_q[$];
  out_item_t ring_reply_q[$];

  // Mirror of the ring contents and the write run in progress
  logic [BYTE_W-1:0]    slot_mem [SLOT_COUNT][SLOT_BYTES];
  logic [MSG_LEN_W-1:0] slot_len [SLOT_COUNT];
  logic [BYTE_W-1:0]    stage_buf [SLOT_BYTES];
  logic [IDX_W-1:0]     head_idx  = '0;
  logic [IDX_W-1:0]     tail_idx  = '0;
  logic [IDX_W:0]       fill_lvl  = '0;
  logic [BYTE_W-1:0]    run_bytes = '0;
  logic                 nul_seen  = 1'b0;
  logic [MSG_LEN_W-1:0] text_len  = '0;

  int err_cnt     = 0;
  int acc_cnt     = 0;
  int total_items = 0;
  int drv_cnt     = 0;
  int rcv_cnt     = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int stall_cnt   = 0;

  message_ring_buffer #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_BYTES(SLOT_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Work out the replies that one accepted operation causes
  task automatic predict_ring_op(input in_item_t op);
    out_item_t            rep;
    logic [MSG_LEN_W-1:0] len;
    int                   k;
    rep = '0;
    if (op.opcode == OP_WRITE) begin
      if (!nul_seen) begin
        if (op.data_byte == NUL_BYTE) begin
          nul_seen = 1'b1;
        end else if (text_len < SLOT_BYTES - 1) begin
          stage_buf[text_len] = op.data_byte;
          text_len = text_len + 1'b1;
        end
      end
      if (run_bytes != WPOS_MAX) run_bytes = run_bytes + 1'b1;
      if (op.last_byte) begin
        rep.last_result = 1'b1;
        if (run_bytes >= SLOT_BYTES || !nul_seen) begin
          rep.status = ST_INVALID;
        end else if (fill_lvl >= SLOT_COUNT) begin
          rep.status = ST_FULL;
        end else begin
          for (k = 0; k < text_len; k++) slot_mem[head_idx][k] = stage_buf[k];
          slot_len[head_idx] = text_len;
          head_idx = (head_idx == SLOT_COUNT - 1) ? '0 : head_idx + 1'b1;
          fill_lvl = fill_lvl + 1'b1;
          rep.status = ST_OK;
        end
        ring_reply_q.push_back(rep);
        run_bytes = '0;
        nul_seen  = 1'b0;
        text_len  = '0;
      end
    end else if (fill_lvl == 0) begin
      rep.status      = ST_EMPTY;
      rep.last_result = 1'b1;
      ring_reply_q.push_back(rep);
    end else begin
      len = slot_len[tail_idx];
      if (len >= op.max_len) begin
        rep.status      = ST_INVALID;
        rep.msg_length  = len;
        rep.last_result = 1'b1;
        ring_reply_q.push_back(rep);
      end else begin
        for (k = 0; k < len; k++) begin
          rep          = '0;
          rep.status   = ST_OK;
          rep.out_byte = slot_mem[tail_idx][k];
          ring_reply_q.push_back(rep);
        end
        rep             = '0;
        rep.status      = ST_OK;
        rep.msg_length  = len;
        rep.last_result = 1'b1;
        ring_reply_q.push_back(rep);
        tail_idx = (tail_idx == SLOT_COUNT - 1) ? '0 : tail_idx + 1'b1;
        fill_lvl = fill_lvl - 1'b1;
      end
    end
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last);
    in_item_t op;
    op.opcode    = OP_WRITE;
    op.data_byte = data;
    op.last_byte = last;
    op.max_len   = BYTE_W'($urandom_range(0, 255));
    op_feed_q.push_back(op);
  endtask

  // Run of run_len bytes with the terminator at nul_at; no terminator when nul_at < 0
  task automatic push_msg(input int run_len, input int nul_at);
    logic [BYTE_W-1:0] data;
    int                k;
    for (k = 0; k < run_len; k++) begin
      if (k == nul_at) data = NUL_BYTE;
      else if (nul_at >= 0 && k > nul_at) data = BYTE_W'($urandom_range(0, 255));
      else data = BYTE_W'($urandom_range(1, 255));
      push_byte(data, k == run_len - 1);
    end
  endtask

  task automatic push_read(input logic [BYTE_W-1:0] limit);
    in_item_t op;
    op.opcode    = OP_READ;
    op.data_byte = BYTE_W'($urandom_range(0, 255));
    op.last_byte = 1'($urandom_range(0, 1));
    op.max_len   = limit;
    op_feed_q.push_back(op);
  endtask

  // Driver: hold valid and payload until the transfer happens
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (op_feed_q.size() != 0 &&
          ((drv_cnt >= DRV_CALM_LO && drv_cnt < DRV_CALM_HI) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= op_feed_q.pop_front();
        drv_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the ring up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rcv_cnt++;
      if (!hold_done && rcv_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (rcv_cnt >= RCV_CALM_LO && rcv_cnt < RCV_CALM_HI) ||
                     ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: check the output transfer, then record the input transfer
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (ring_reply_q.size() == 0) begin
          $error("unexpected reply: out_byte=%0d status=%0d msg_length=%0d last_result=%0b",
                 out_data.out_byte, out_data.status, out_data.msg_length,
                 out_data.last_result);
          err_cnt++;
        end else begin
          want = ring_reply_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", want.out_byte, out_data.out_byte);
            err_cnt++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            err_cnt++;
          end
          if (out_data.msg_length !== want.msg_length) begin
            $error("msg_length: expected %0d, actual %0d", want.msg_length,
                   out_data.msg_length);
            err_cnt++;
          end
          if (out_data.last_result !== want.last_result) begin
            $error("last_result: expected %0b, actual %0b", want.last_result,
                   out_data.last_result);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_ring_op(in_data);
        acc_cnt++;
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    int pick;
    int run_len;
    // empty ring, then a message holding only the terminator
    push_read(8'hFF);
    push_msg(1, 0);
    push_read(8'd0);
    push_read(8'd1);
    // longest text that fits, read with a limit just too small, then just big enough
    push_byte(8'hFF, 1'b0);
    push_msg(30, 29);
    push_read(8'd30);
    push_read(8'd31);
    // one byte too long, no terminator, text cut short by an early terminator
    push_msg(32, 31);
    push_msg(5, -1);
    push_msg(10, 3);
    // read in the middle of a write run
    push_byte(8'h5A, 1'b0);
    push_read(8'hFF);
    push_byte(NUL_BYTE, 1'b1);
    // fill the ring, overflow it, then drain past empty
    repeat (SLOT_COUNT - 1) begin
      run_len = $urandom_range(1, 4);
      push_msg(run_len, run_len - 1);
    end
    push_msg(2, 1);
    repeat (SLOT_COUNT + 1) push_read(8'hFF);

    while (op_feed_q.size() < FEED_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_read(($urandom_range(4) == 0) ? BYTE_W'($urandom_range(0, 31))
                                           : BYTE_W'($urandom_range(31, 255)));
      end else if (pick < 85) begin
        run_len = ($urandom_range(9) == 0) ? $urandom_range(16, 31) : $urandom_range(1, 10);
        push_msg(run_len, ($urandom_range(3) == 0) ? $urandom_range(0, run_len - 1)
                                                    : run_len - 1);
      end else if (pick < 92) begin
        push_msg($urandom_range(1, 8), -1);
      end else if (pick < 96) begin
        push_msg($urandom_range(32, 40), $urandom_range(0, 31));
      end else begin
        push_byte(BYTE_W'($urandom_range(1, 255)), 1'b0);
        push_read(BYTE_W'($urandom_range(0, 255)));
        push_byte(NUL_BYTE, 1'b1);
      end
    end
    total_items = op_feed_q.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (acc_cnt != total_items) @(posedge clk_i);
    while (ring_reply_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (ring_reply_q.size() != 0) begin
      $error("%0d replies never arrived", ring_reply_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
